// ----- rtl/ups_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ups_pkg
// Shared types and constants for the UTF-8 punctuation splitter: the result
// bundle that one text byte produces, and the queue sizing default.
// ----------------------------------------------------------------------------
package ups_pkg;

  // Most result words one text byte can produce
  localparam int MaxResults = 5;
  localparam int CntW       = $clog2(MaxResults + 1);

  // Default depth of the bundle queue between front and back
  localparam int QueueDepthDefault = 4;

  // UTF-8 lead byte classes
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [2:0] Lead2Code  = 3'h6;
  localparam logic [3:0] Lead3Code  = 4'hE;
  localparam logic [4:0] Lead4Code  = 5'h1E;

  // All result words caused by one text byte
  typedef struct packed {
    logic [MaxResults-1:0][7:0] data;      // token bytes, entry 0 first
    logic [MaxResults-1:0]      tok_end;   // token_end per entry
    logic [CntW-1:0]            cnt;       // number of entries, 1..MaxResults
    logic                       marker;    // single marker-only entry
    logic                       text_end;  // last entry closes the text
  } ups_cmd_t;

endpackage : ups_pkg
`default_nettype wire

// ----- rtl/utf8_punctuation_splitter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_punctuation_splitter_top
// Splits UTF-8 text into tokens at whitespace and punctuation, one byte per
// word in, token bytes with end marks out.
//
//   channel | dir | handshake                | payload
//   text    | in  | text_valid, text_stall   | text_byte, text_last
//   token   | out | token_valid, token_stall | token_byte, has_byte, token_end, text_end, run_last
//
// The front takes one text word per cycle unless the bundle queue is full.
// Each text word yields 0 to 5 token words; the back emits one per cycle while token_stall is low,
// so output bandwidth sets the sustained rate for bursty text.
// A token word is offered only after its text word has passed through the bundle queue and the output register.
// Reset (rst, synchronous) empties the queue and clears token state.
// token_stall backs up into the queue only; text_stall rises when it is full.
// ----------------------------------------------------------------------------
module utf8_punctuation_splitter_top #(
  parameter int QueueDepth = ups_pkg::QueueDepthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       text_valid,
  output logic            text_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       text_last,
  output logic            token_valid,
  input  wire logic       token_stall,
  output logic [7:0]      token_byte,
  output logic            has_byte,
  output logic            token_end,
  output logic            text_end,
  output logic            run_last
);
  import ups_pkg::*;

  logic     q_full, push, pop, head_valid;
  ups_cmd_t push_cmd, head_cmd;

  assign text_stall = q_full;

  ups_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_byte  (text_byte),
    .text_last  (text_last),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  ups_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  ups_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_byte  (token_byte),
    .has_byte    (has_byte),
    .token_end   (token_end),
    .text_end    (text_end),
    .run_last    (run_last)
  );

endmodule : utf8_punctuation_splitter_top
`default_nettype wire

// ----- rtl/ups_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ups_front
// Accepts text bytes, tracks the open token and any pending multi-byte
// sequence, and turns each byte that yields result words into one bundle of them.
// ----------------------------------------------------------------------------
module ups_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            text_valid,
  input  wire logic [7:0]      text_byte,
  input  wire logic            text_last,
  input  wire logic            q_full,
  output logic                 push,
  output ups_pkg::ups_cmd_t    cmd
);
  import ups_pkg::*;

  // C-locale whitespace
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // C-locale punctuation
  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  // State; a token is open exactly when a held byte is valid
  logic       held_valid, held_valid_next;
  logic [7:0] held_byte, held_byte_next;
  logic [1:0] pend_total, pend_total_next;
  logic [1:0] pend_count, pend_count_next;
  logic [7:0] pend_bytes [3];

  logic       accept;
  logic       pb_we;
  logic [1:0] pb_idx;

  assign accept = text_valid && !q_full;

  // Classify the byte and build its result bundle
  always_comb begin
    logic [CntW-1:0] n;
    logic [1:0]      need;
    ups_cmd_t        c;
    c               = '0;
    n               = '0;
    need            = 2'd0;
    held_valid_next = held_valid;
    held_byte_next  = held_byte;
    pend_total_next = pend_total;
    pend_count_next = pend_count;
    pb_we           = 1'b0;
    pb_idx          = 2'd0;

    if (pend_total != 2'd0) begin
      if (({1'b0, pend_count} + 3'd1) >= {1'b0, pend_total}) begin
        // sequence complete: release held byte and the sequence
        if (held_valid) begin
          c.data[n] = held_byte;
          n = n + 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
          if (2'(i) <= pend_count) begin
            c.data[n] = pend_bytes[i];
            n = n + 1'b1;
          end
        end
        held_byte_next  = text_byte;
        held_valid_next = 1'b1;
        pend_total_next = 2'd0;
        pend_count_next = 2'd0;
      end else begin
        // any byte counts as a continuation
        pb_we           = 1'b1;
        pb_idx          = pend_count + 2'd1;
        pend_count_next = pend_count + 2'd1;
      end
    end else if (text_byte < AsciiLimit) begin
      if (is_space(text_byte) || is_punct(text_byte)) begin
        if (held_valid) begin
          c.data[n]    = held_byte;
          c.tok_end[n] = 1'b1;
          n = n + 1'b1;
        end
        held_valid_next = 1'b0;
        if (is_punct(text_byte)) begin
          c.data[n]    = text_byte;
          c.tok_end[n] = 1'b1;
          n = n + 1'b1;
        end
      end else begin
        if (held_valid) begin
          c.data[n] = held_byte;
          n = n + 1'b1;
        end
        held_byte_next  = text_byte;
        held_valid_next = 1'b1;
      end
    end else begin
      // lead byte length
      if (text_byte[7:5] == Lead2Code)      need = 2'd1;
      else if (text_byte[7:4] == Lead3Code) need = 2'd2;
      else if (text_byte[7:3] == Lead4Code) need = 2'd3;
      if (need == 2'd0) begin
        // invalid lead: kept only inside a token
        if (held_valid) begin
          c.data[n] = held_byte;
          n = n + 1'b1;
          held_byte_next = text_byte;
        end
      end else begin
        pend_total_next = need;
        pend_count_next = 2'd0;
        pb_we           = 1'b1;
        pb_idx          = 2'd0;
      end
    end

    // End of text: flush held byte, drop a cut-short sequence
    if (text_last) begin
      if (held_valid_next) begin
        c.data[n]    = held_byte_next;
        c.tok_end[n] = 1'b1;
        n = n + 1'b1;
      end
      held_valid_next = 1'b0;
      pend_total_next = 2'd0;
      pend_count_next = 2'd0;
      if (n == '0) begin
        c.marker = 1'b1;
        n = n + 1'b1;
      end
      c.text_end = 1'b1;
    end

    c.cnt = n;
    cmd   = c;
    push  = accept && (n != '0);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      pend_total <= 2'd0;
      pend_count <= 2'd0;
    end else if (accept) begin
      held_valid <= held_valid_next;
      pend_total <= pend_total_next;
      pend_count <= pend_count_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= held_byte_next;
      if (pb_we) pend_bytes[pb_idx] <= text_byte;
    end
  end

  // Final byte leaves nothing behind
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && text_last |=> !held_valid && pend_total == 2'd0)
    else $error("state not cleared after final byte");

  // A final byte always produces at least one word
  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    accept && text_last |-> push)
    else $error("final byte produced no word");

endmodule : ups_front
`default_nettype wire

// ----- rtl/ups_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ups_queue
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module ups_queue #(
  parameter int Depth = ups_pkg::QueueDepthDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire ups_pkg::ups_cmd_t  push_cmd,
  input  wire logic               pop,
  output logic                    full,
  output logic                    head_valid,
  output ups_pkg::ups_cmd_t       head_cmd
);
  import ups_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntQ = $clog2(Depth + 1);

  ups_cmd_t         entries [Depth];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntQ-1:0]  count;

  assign full       = (count == CntQ'(Depth));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule : ups_queue
`default_nettype wire

// ----- rtl/ups_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ups_back
// Walks the head bundle into the output register, one entry per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module ups_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               head_valid,
  input  wire ups_pkg::ups_cmd_t  head_cmd,
  output logic                    pop,
  output logic                    token_valid,
  input  wire logic               token_stall,
  output logic [7:0]              token_byte,
  output logic                    has_byte,
  output logic                    token_end,
  output logic                    text_end,
  output logic                    run_last
);
  import ups_pkg::*;

  logic [CntW-1:0] idx;
  logic            load;
  logic            is_last;

  assign load    = head_valid && (!token_valid || !token_stall);
  assign is_last = (idx == head_cmd.cnt - 1'b1);
  assign pop     = load && is_last;

  // Output valid and entry index
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      idx         <= '0;
    end else if (load) begin
      token_valid <= 1'b1;
      idx         <= is_last ? '0 : idx + 1'b1;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (load) begin
      token_byte <= head_cmd.data[idx];
      has_byte   <= !head_cmd.marker;
      token_end  <= head_cmd.tok_end[idx];
      text_end   <= is_last && head_cmd.text_end;
      run_last   <= is_last;
    end
  end

  // A marker word is always the whole result of a final byte
  a_marker_alone: assert property (@(posedge clk) disable iff (rst)
    token_valid && !has_byte |-> run_last && text_end && !token_end)
    else $error("marker word not alone at text end");

  // Index stays inside the head bundle
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx < head_cmd.cnt)
    else $error("entry index beyond bundle");

endmodule : ups_back
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks utf8_punctuation_splitter_top against a cycle-free token splitter
// model kept in a scoreboard class. Directed texts cover the byte classes and
// corner cases first. Random texts with words, marks, UTF-8 sequences and
// noise follow, under three idle patterns and one long token-side hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int StallLimit  = 2000;  // cycles without any accepted word
  localparam int HoldCycles  = 80;    // long token-side hold-off
  localparam int PhaseItems  = 120;   // random text words per idle phase
  localparam int DrainCycles = 20;
  localparam int ReportMax   = 10;

  // One token word as seen on the output channel
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       tok_end;
    logic       txt_end;
    logic       run_end;
  } token_word_t;

  // Token splitter model plus the queue of token words still owed
  class token_scoreboard;
    token_word_t expected_tokens[$];
    int          mismatches;
    logic        token_open;
    logic        held_valid;
    logic [7:0]  held_byte;
    logic [1:0]  seq_need;
    logic [1:0]  seq_got;
    logic [7:0]  seq_bytes[3];

    function new();
      mismatches = 0;
      token_open = 1'b0;
      held_valid = 1'b0;
      held_byte  = 8'h00;
      seq_need   = 2'd0;
      seq_got    = 2'd0;
      foreach (seq_bytes[i]) seq_bytes[i] = 8'h00;
    endfunction

    static function bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    static function bit is_mark(logic [7:0] c);
      return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
             (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    static function token_word_t word_of(logic [7:0] b, logic h, logic e);
      return '{data: b, has: h, tok_end: e, txt_end: 1'b0, run_end: 1'b0};
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    // Advance the splitter by one accepted text word
    function void note_text(logic [7:0] c, logic last);
      token_word_t run[$];
      logic [1:0]  lead_need;
      lead_need = 2'd0;
      if (seq_need != 2'd0) begin
        // every byte counts as a continuation, whatever its value
        if (seq_got + 1 >= seq_need) begin
          if (held_valid) run = {run, word_of(held_byte, 1'b1, 1'b0)};
          for (int i = 0; i <= seq_got && i < 3; i++)
            run = {run, word_of(seq_bytes[i], 1'b1, 1'b0)};
          held_byte  = c;
          held_valid = 1'b1;
          token_open = 1'b1;
          seq_need   = 2'd0;
          seq_got    = 2'd0;
        end else begin
          if (seq_got + 1 < 3) seq_bytes[seq_got + 1] = c;
          seq_got = seq_got + 2'd1;
        end
      end else if (c < ups_pkg::AsciiLimit) begin
        if (is_blank(c) || is_mark(c)) begin
          if (held_valid) run = {run, word_of(held_byte, 1'b1, 1'b1)};
          held_valid = 1'b0;
          token_open = 1'b0;
          if (is_mark(c)) run = {run, word_of(c, 1'b1, 1'b1)};
        end else begin
          if (held_valid) run = {run, word_of(held_byte, 1'b1, 1'b0)};
          held_byte  = c;
          held_valid = 1'b1;
          token_open = 1'b1;
        end
      end else begin
        if (c[7:5] == ups_pkg::Lead2Code)      lead_need = 2'd1;
        else if (c[7:4] == ups_pkg::Lead3Code) lead_need = 2'd2;
        else if (c[7:3] == ups_pkg::Lead4Code) lead_need = 2'd3;
        if (lead_need != 2'd0) begin
          seq_need     = lead_need;
          seq_got      = 2'd0;
          seq_bytes[0] = c;
        end else if (token_open && held_valid) begin
          // bad lead byte rides along inside an open token
          run = {run, word_of(held_byte, 1'b1, 1'b0)};
          held_byte = c;
        end
      end

      // end of text flushes the held byte; a partial sequence is lost
      if (last) begin
        if (held_valid) run = {run, word_of(held_byte, 1'b1, 1'b1)};
        token_open = 1'b0;
        held_valid = 1'b0;
        held_byte  = 8'h00;
        seq_need   = 2'd0;
        seq_got    = 2'd0;
        if (run.size() == 0) run = {run, word_of(8'h00, 1'b0, 1'b0)};
        run[run.size() - 1].txt_end = 1'b1;
      end
      if (run.size() > 0) run[run.size() - 1].run_end = 1'b1;
      expected_tokens = {expected_tokens, run};
    endfunction

    // Compare one accepted token word with the oldest expectation
    function void check_token(token_word_t got);
      token_word_t want;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: token word with none expected: %s %h has %b end %b %s %b %s %b",
                   $time, "byte", got.data, got.has, got.tok_end,
                   "text_end", got.txt_end, "run_last", got.run_end);
        return;
      end
      want = expected_tokens.pop_front();
      if (got.data !== want.data || got.has !== want.has || got.tok_end !== want.tok_end ||
          got.txt_end !== want.txt_end || got.run_end !== want.run_end) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: token word exp byte %h has %b end %b text_end %b run_last %b %s",
                   $time, want.data, want.has, want.tok_end, want.txt_end, want.run_end,
                   $sformatf("/ got %h %b %b %b %b", got.data, got.has, got.tok_end,
                             got.txt_end, got.run_end));
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       text_valid = 1'b0;
  logic       text_stall;
  logic [7:0] text_byte = 8'h00;
  logic       text_last = 1'b0;
  logic       token_valid;
  logic       token_stall = 1'b0;
  logic [7:0] token_byte;
  logic       has_byte;
  logic       token_end;
  logic       text_end;
  logic       run_last;

  token_scoreboard sb;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_request = 1'b0;
  logic [7:0]  text_bytes[$];

  utf8_punctuation_splitter_top u_top (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_byte   (text_byte),
    .text_last   (text_last),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_byte  (token_byte),
    .has_byte    (has_byte),
    .token_end   (token_end),
    .text_end    (text_end),
    .run_last    (run_last)
  );

  always #1 clk = ~clk;

  // Offer one text word, with random idle cycles ahead of it
  task automatic send_text_word(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    text_last  <= l;
    do @(posedge clk); while (text_stall);
    sb.note_text(b, l);
  endtask

  // Send the whole text in text_bytes, last flag on the final byte
  task automatic send_text();
    foreach (text_bytes[i]) send_text_word(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  // Append one byte to the text being built
  function automatic void add_byte(logic [7:0] b);
    text_bytes = {text_bytes, b};
  endfunction

  function automatic logic [7:0] seq_lead(int n);
    if (n == 2) return {3'b110, 5'($urandom)};
    if (n == 3) return {4'b1110, 4'($urandom)};
    return {5'b11110, 3'($urandom)};
  endfunction

  function automatic logic [7:0] seq_tail();
    if ($urandom_range(7) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // Random text: mostly words, blanks, marks and UTF-8 sequences, some noise
  function automatic void build_text();
    int         pieces;
    int         kind;
    int         n;
    logic [7:0] c;
    text_bytes = {};
    pieces = $urandom_range(1, 6);
    for (int p = 0; p < pieces; p++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
          do c = 8'($urandom_range(127));
          while (token_scoreboard::is_blank(c) || token_scoreboard::is_mark(c));
          add_byte(c);
        end
      end else if (kind < 55) begin
        n = $urandom_range(6);
        add_byte(n == 6 ? 8'h20 : 8'h09 + 8'(n));
      end else if (kind < 70) begin
        do c = 8'($urandom_range(127)); while (!token_scoreboard::is_mark(c));
        add_byte(c);
      end else if (kind < 90) begin
        n = $urandom_range(2, 4);
        add_byte(seq_lead(n));
        for (int k = 1; k < n; k++) add_byte(seq_tail());
      end else if (kind < 95) begin
        add_byte($urandom_range(1) ? 8'h80 + 8'($urandom_range(63))
                                   : 8'hF8 + 8'($urandom_range(7)));
      end else begin
        add_byte(8'($urandom));
      end
    end
    // sometimes the text stops in the middle of a sequence
    if ($urandom_range(4) == 0) begin
      n = $urandom_range(2, 4);
      add_byte(seq_lead(n));
      for (int k = $urandom_range(n - 2); k > 0; k--) add_byte(seq_tail());
    end
  endfunction

  // Token side: check accepted words, drive stall
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && token_valid && !token_stall)
        sb.check_token('{data: token_byte, has: has_byte, tok_end: token_end,
                         txt_end: text_end, run_end: run_last});
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        token_stall <= 1'b1;
      end else begin
        token_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any accepted word
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((text_valid && !text_stall) || (token_valid && !token_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("utf8_punctuation_splitter_top: mismatch");
    $finish;
  end

  // Main sequence
  initial begin
    int sent;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // lone blank gives a marker-only word
    text_bytes = '{8'h20};
    send_text();
    // control bytes form tokens, bad lead inside a token, mark closes it
    text_bytes = '{8'h00, 8'h7F, 8'hFF, 8'h2E};
    send_text();
    // bad lead with no token open is dropped
    text_bytes = '{8'h80, 8'h41};
    send_text();
    // blank and mark range edges
    text_bytes = '{8'h09, 8'h0D, 8'h21, 8'h7E, 8'h40, 8'h60};
    send_text();
    // four-byte sequence ending the text: most words from one byte
    text_bytes = '{8'h61, 8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text();
    // blank taken as a continuation, then a mark
    text_bytes = '{8'hC3, 8'h20, 8'h2C};
    send_text();
    // three-byte sequence, then a mark
    text_bytes = '{8'hE2, 8'h82, 8'hAC, 8'h5B};
    send_text();
    // sequence cut short by the end of text
    text_bytes = '{8'h7A, 8'hE2, 8'h82};
    send_text();

    // random texts under three idle patterns
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 6 : 0;
      if (phase == 2) hold_request = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        build_text();
        send_text();
        sent += text_bytes.size();
      end
    end
    text_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("utf8_punctuation_splitter_top: match");
    else
      $display("utf8_punctuation_splitter_top: mismatch");
    $finish;
  end

endmodule
